// ----- design/pidci_pkg.sv -----
// ----------------------------------------------------------------------------
// pidci_pkg: shared types and constants
// Register map codes, loop mode and clamp codes, and the command that the
// control sequencer hands to the serial multiplier.
// ----------------------------------------------------------------------------
package pidci_pkg;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_KP   = 3'd0;
    localparam logic [2:0] REG_KI   = 3'd1;
    localparam logic [2:0] REG_KD   = 3'd2;
    localparam logic [2:0] REG_MIN  = 3'd3;
    localparam logic [2:0] REG_MAX  = 3'd4;
    localparam logic [2:0] REG_MODE = 3'd5;

    // Loop modes; the unused code runs as PID
    localparam logic [1:0] MODE_PID = 2'd0;
    localparam logic [1:0] MODE_PI  = 2'd1;
    localparam logic [1:0] MODE_PD  = 2'd2;

    // Clamp status codes
    localparam logic [1:0] CS_WITHIN = 2'd0;
    localparam logic [1:0] CS_MAX    = 2'd1;
    localparam logic [1:0] CS_MIN    = 2'd2;

    // Integration only for 0 < step < this limit (microseconds)
    localparam logic [15:0] DT_LIMIT_US = 16'd10000;

    // Serial multiplier geometry
    localparam int MCAND_W  = 32;
    localparam int MPLIER_W = 48;
    localparam int PROD_W   = MCAND_W + MPLIER_W;
    localparam int SHORT_W  = 16;

    // Command from the sequencer to the multiplier
    typedef struct packed {
        logic start;          // capture operands and begin
        logic long_op;        // 48-bit multiplier, else 16-bit
        logic mplier_signed;  // top multiplier bit has negative weight
    } t_mul_cmd;

endpackage

// ----- design/pidci_in_if.sv -----
// ----------------------------------------------------------------------------
// pidci_in_if: input item channel
// Valid/ready channel carrying error, rate and time step of one update.
// ----------------------------------------------------------------------------
interface pidci_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] error_in;
    logic signed [15:0] rate_in;
    logic        [15:0] step_us;

    modport source (output valid, output error_in, output rate_in, output step_us,
                    input ready);
    modport sink   (input valid, input error_in, input rate_in, input step_us,
                    output ready);
endinterface

// ----- design/pidci_out_if.sv -----
// ----------------------------------------------------------------------------
// pidci_out_if: result item channel
// Valid/ready channel carrying the clamped drive and the clamp status.
// ----------------------------------------------------------------------------
interface pidci_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] drive_out;
    logic        [1:0]  clamp_state;

    modport source (output valid, output drive_out, output clamp_state, input ready);
    modport sink   (input valid, input drive_out, input clamp_state, output ready);
endinterface

// ----- design/pidci_mul.sv -----
// ----------------------------------------------------------------------------
// pidci_mul: bit-serial shift-add multiplier
// Signed 32-bit multiplicand times a 16- or 48-bit multiplier, one multiplier
// bit per cycle, LSB first; one 34-bit adder forms every partial sum.
// ----------------------------------------------------------------------------
module pidci_mul
    import pidci_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_mul_cmd                  i_cmd,
    input  logic signed [MCAND_W-1:0] i_mcand,
    input  logic [MPLIER_W-1:0]       i_mplier,
    output logic                      o_done,
    output logic signed [PROD_W-1:0]  o_prod
);

    localparam int HI_W  = MCAND_W + 2;
    localparam int CNT_W = $clog2(MPLIER_W);
    localparam logic [CNT_W-1:0] LAST_LONG  = CNT_W'(MPLIER_W - 1);
    localparam logic [CNT_W-1:0] LAST_SHORT = CNT_W'(SHORT_W - 1);

    logic                      r_busy;
    logic                      r_done;
    logic                      r_long;
    logic                      r_sgn;
    logic [CNT_W-1:0]          r_cnt;
    logic signed [MCAND_W-1:0] r_mcand;
    logic signed [HI_W-1:0]    r_hi;
    logic [MPLIER_W-1:0]       r_lo;

    logic                      w_last;
    logic signed [HI_W-1:0]    w_mc;
    logic signed [HI_W-1:0]    w_addend;
    logic signed [HI_W-1:0]    w_sum;

    // Partial product for the current multiplier bit
    always_comb begin
        w_last = (r_cnt == (r_long ? LAST_LONG : LAST_SHORT));
        w_mc   = HI_W'(r_mcand);
        if (!r_lo[0]) begin
            w_addend = '0;
        end else if (w_last && r_sgn) begin
            w_addend = -w_mc;
        end else begin
            w_addend = w_mc;
        end
        w_sum = r_hi + w_addend;
    end

    // Control: step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // Datapath: arithmetic right shift of {hi, lo} after each add
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mcand <= i_mcand;
            r_long  <= i_cmd.long_op;
            r_sgn   <= i_cmd.mplier_signed;
            r_hi    <= '0;
            r_lo    <= i_mplier;
        end else if (r_busy) begin
            r_hi <= {w_sum[HI_W-1], w_sum[HI_W-1:1]};
            r_lo <= {w_sum[0], r_lo[MPLIER_W-1:1]};
        end
    end

    // Product alignment depends on how many bits were consumed
    always_comb begin
        if (r_long) begin
            o_prod = {r_hi[MCAND_W-1:0], r_lo};
        end else begin
            o_prod = PROD_W'($signed({r_hi[SHORT_W-1:0],
                                      r_lo[MPLIER_W-1 -: SHORT_W]}));
        end
    end

    assign o_done = r_done;

endmodule

// ----- design/pid_with_conditional_integration.sv -----
// ----------------------------------------------------------------------------
// pid_with_conditional_integration: fixed-point PID with conditional
// integration anti-windup, bit-serial multiplier shared by all products.
// Each update runs 16-bit multiplier passes for the P and D products and a
// 48-bit pass for the integral term; an update that integrates adds a
// 16-bit error-times-step pass and a second 48-bit integral pass, all on the
// one-bit-per-cycle multiplier. One item in flight; the next input is taken
// once the sequencer is idle, even while a result waits for transfer.
// Reset (synchronous, active low): registers to defaults, integral to zero.
// ----------------------------------------------------------------------------
module pid_with_conditional_integration
    import pidci_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    pidci_in_if.sink           i_in,
    pidci_out_if.source        o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_P, S_MUL_D, S_MUL_I1, S_RAW1, S_DECIDE,
        S_MUL_EU, S_MUL_I2, S_RAW2, S_CLAMP
    } t_state;

    // Configuration registers
    logic signed [15:0] r_kp;
    logic signed [31:0] r_ki;
    logic signed [15:0] r_kd;
    logic signed [15:0] r_out_min;
    logic signed [15:0] r_out_max;
    logic        [1:0]  r_mode;

    // Sequencer and datapath registers
    t_state             r_state;
    logic               r_kick;
    logic signed [15:0] r_e;
    logic signed [15:0] r_r;
    logic        [15:0] r_us;
    logic signed [31:0] r_p;
    logic signed [31:0] r_d;
    logic signed [47:0] r_integ;
    logic signed [51:0] r_iterm;
    logic signed [53:0] r_raw;
    logic               r_out_valid;
    logic signed [15:0] r_drive;
    logic        [1:0]  r_cs;

    // Multiplier hookup
    t_mul_cmd                  w_cmd;
    logic signed [MCAND_W-1:0] w_mcand;
    logic [MPLIER_W-1:0]       w_mplier;
    logic                      w_done;
    logic signed [PROD_W-1:0]  w_prod;

    logic                      w_cfg_wr;
    logic                      w_pd;
    logic                      w_pi;
    logic signed [53:0]        w_raw_new;
    logic signed [53:0]        w_hi_lim;
    logic signed [53:0]        w_lo_lim;
    logic                      w_int_en;
    logic                      w_go;
    logic signed [48:0]        w_sum;
    logic signed [47:0]        w_sat;
    logic                      w_out_free;

    // APB register writes
    assign w_cfg_wr = psel && penable && pwrite;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp      <= '0;
            r_ki      <= '0;
            r_kd      <= '0;
            r_out_min <= 16'sh8000;
            r_out_max <= 16'sh7FFF;
            r_mode    <= MODE_PID;
        end else if (w_cfg_wr) begin
            unique case (paddr[4:2])
                REG_KP:   r_kp      <= pwdata[15:0];
                REG_KI:   r_ki      <= pwdata;
                REG_KD:   r_kd      <= pwdata[15:0];
                REG_MIN:  r_out_min <= pwdata[15:0];
                REG_MAX:  r_out_max <= pwdata[15:0];
                REG_MODE: r_mode    <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // APB register reads
    always_comb begin
        unique case (paddr[4:2])
            REG_KP:   prdata = 32'(r_kp);
            REG_KI:   prdata = r_ki;
            REG_KD:   prdata = 32'(r_kd);
            REG_MIN:  prdata = 32'(r_out_min);
            REG_MAX:  prdata = 32'(r_out_max);
            REG_MODE: prdata = {30'd0, r_mode};
            default:  prdata = '0;
        endcase
    end

    // Multiplier operands by sequencer step
    always_comb begin
        w_cmd.start         = r_kick;
        w_cmd.long_op       = 1'b0;
        w_cmd.mplier_signed = 1'b1;
        w_mcand             = r_ki;
        w_mplier            = MPLIER_W'(r_integ);
        unique case (r_state)
            S_MUL_P: begin
                w_mcand  = MCAND_W'(r_kp);
                w_mplier = MPLIER_W'(unsigned'(r_e));
            end
            S_MUL_D: begin
                w_mcand  = MCAND_W'(r_kd);
                w_mplier = MPLIER_W'(unsigned'(r_r));
            end
            S_MUL_EU: begin
                w_mcand             = MCAND_W'(r_e);
                w_mplier            = MPLIER_W'(r_us);
                w_cmd.mplier_signed = 1'b0;
            end
            S_MUL_I1, S_MUL_I2: begin
                w_cmd.long_op = 1'b1;
            end
            default: ;
        endcase
    end

    pidci_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_mcand  (w_mcand),
        .i_mplier (w_mplier),
        .o_done   (w_done),
        .o_prod   (w_prod)
    );

    // Raw output, limits and the anti-windup decision
    always_comb begin
        w_pd      = (r_mode == MODE_PD);
        w_pi      = (r_mode == MODE_PI);
        w_raw_new = 54'(r_p) + 54'(r_iterm) - 54'(r_d);
        w_hi_lim  = 54'($signed({r_out_max, 16'h0000}));
        w_lo_lim  = 54'($signed({r_out_min, 16'h0000}));
        w_int_en  = !w_pd && (r_ki != '0) && (r_us != '0) && (r_us < DT_LIMIT_US);
        w_go      = ((r_raw > w_hi_lim) && (r_e < 0)) ||
                    ((r_raw < w_lo_lim) && (r_e > 0)) ||
                    ((r_raw >= w_lo_lim) && (r_raw < w_hi_lim));
        // saturating integral update from error times step
        w_sum     = 49'(r_integ) + 49'(signed'(w_prod[32:0]));
        if (w_sum[48:47] == 2'b01) begin
            w_sat = 48'sh7FFF_FFFF_FFFF;
        end else if (w_sum[48:47] == 2'b10) begin
            w_sat = 48'sh8000_0000_0000;
        end else begin
            w_sat = w_sum[47:0];
        end
        w_out_free = !r_out_valid || o_out.ready;
    end

    // Sequencer with registered results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kick      <= 1'b0;
            r_out_valid <= 1'b0;
            r_integ     <= '0;
        end else begin
            r_kick <= 1'b0;
            // a transfer frees the result register unless a new result refills it
            if (r_out_valid && o_out.ready && (r_state != S_CLAMP)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_e     <= i_in.error_in;
                        r_r     <= i_in.rate_in;
                        r_us    <= i_in.step_us;
                        r_state <= S_MUL_P;
                        r_kick  <= 1'b1;
                    end
                end
                S_MUL_P: begin
                    if (w_done) begin
                        r_p     <= w_prod[31:0];
                        r_state <= S_MUL_D;
                        r_kick  <= 1'b1;
                    end
                end
                S_MUL_D: begin
                    if (w_done) begin
                        r_d     <= w_pi ? 32'sd0 : w_prod[31:0];
                        r_state <= S_MUL_I1;
                        r_kick  <= 1'b1;
                    end
                end
                S_MUL_I1: begin
                    if (w_done) begin
                        r_iterm <= w_pd ? 52'sd0 : w_prod[79:28];
                        r_state <= S_RAW1;
                    end
                end
                S_RAW1: begin
                    r_raw   <= w_raw_new;
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    // integral unchanged: the raw output stands as computed
                    if (w_int_en && w_go) begin
                        r_state <= S_MUL_EU;
                        r_kick  <= 1'b1;
                    end else begin
                        r_state <= S_CLAMP;
                    end
                end
                S_MUL_EU: begin
                    if (w_done) begin
                        r_integ <= w_sat;
                        r_state <= S_MUL_I2;
                        r_kick  <= 1'b1;
                    end
                end
                S_MUL_I2: begin
                    if (w_done) begin
                        r_iterm <= w_prod[79:28];
                        r_state <= S_RAW2;
                    end
                end
                S_RAW2: begin
                    r_raw   <= w_raw_new;
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    // max test first, so inverted limits favor out_max
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        if (r_raw >= w_hi_lim) begin
                            r_drive <= r_out_max;
                            r_cs    <= CS_MAX;
                        end else if (r_raw <= w_lo_lim) begin
                            r_drive <= r_out_min;
                            r_cs    <= CS_MIN;
                        end else begin
                            r_drive <= r_raw[31:16];
                            r_cs    <= CS_WITHIN;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Channel outputs
    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.drive_out   = r_drive;
    assign o_out.clamp_state = r_cs;

endmodule

// ----- tb/tb_pid_with_conditional_integration.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pid_with_conditional_integration: self-checking bench for the PID block
// A directed table (reset values, gain and limit extremes, every loop mode,
// inverted limits, time-step bounds, unmapped register) runs first. Random
// register settings and random updates follow. Typed rows are scored against
// their hand result, all others against a bit-accurate fixed-point predictor.
// The input and output sides idle at random; the output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_pid_with_conditional_integration;
    import pidci_pkg::*;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 6;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 118;
    localparam int HOLD_CYCLES     = 800;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int SETTLE_CYCLES   = 200;
    localparam int RUN_LIMIT_NS    = 12_000_000;

    // Register index with no register behind it, and the spare mode code
    localparam logic [2:0] REG_UNUSED = 3'd6;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // Integral saturation bounds (48-bit signed)
    localparam logic signed [63:0] INTEG_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] INTEG_MIN = -INTEG_MAX - 64'sd1;

    typedef logic signed [15:0] t_s16;

    typedef struct packed {
        logic signed [15:0] drive;
        logic [1:0]         cs;
    } t_drive;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [2:0]  reg_idx;
        logic [31:0] reg_val;
        t_s16        err;
        t_s16        rate;
        logic [15:0] step;
        logic        typed;
        t_s16        exp_drive;
        logic [1:0]  exp_cs;
    } t_dir_row;

    localparam int NUM_DIR = 34;

    // Directed table; typed rows carry a result that is obvious by hand
    localparam t_dir_row DIRECTED [NUM_DIR] = '{
        // after reset: all gains zero
        '{ROW_ITEM, 3'd0, 32'd0, 16'sh7FFF, 16'sh8000, 16'hFFFF, 1'b1, 16'sd0, CS_WITHIN},
        '{ROW_ITEM, 3'd0, 32'd0, 16'sh8000, 16'sh7FFF, 16'h0000, 1'b1, 16'sd0, CS_WITHIN},
        // proportional extremes
        '{ROW_CFG, REG_KP, 32'h0000_7FFF, 16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0, CS_WITHIN},
        '{ROW_ITEM, 3'd0, 32'd0, 16'sh7FFF, 16'sd0, 16'd0, 1'b1, 16'sd16383, CS_WITHIN},
        '{ROW_ITEM, 3'd0, 32'd0, 16'sh8000, 16'sd0, 16'd0, 1'b0, 16'sd0, CS_WITHIN},
        // clamp at max, then at min
        '{ROW_CFG, REG_MAX, 32'd100, 16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0, CS_WITHIN},
        '{ROW_ITEM, 3'd0, 32'd0, 16'sh7FFF, 16'sd0, 16'd1, 1'b1, 16'sd100, CS_MAX},
        '{ROW_CFG, REG_MIN, 32'hFFFF_FF9C, 16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0, CS_WITHIN},
        '{ROW_ITEM, 3'd0, 32'd0, 16'sh8000, 16'sd0, 16'd1, 1'b1, -16'sd100, CS_MIN},
        // most negative rate gain, subtracted rate term
        '{ROW_CFG, REG_KD, 32'h0000_8000, 16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0, CS_WITHIN},
        '{ROW_ITEM, 3'd0, 32'd0, 16'sd0, 16'sh7FFF, 16'd0, 1'b1, 16'sd100, CS_MAX},
        // integration at and around the time-step limit
        '{ROW_CFG, REG_KI, 32'h7FFF_FFFF, 16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0, CS_WITHIN},
        '{ROW_CFG, REG_KP, 32'h0000_0100, 16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0, CS_WITHIN},
        '{ROW_ITEM, 3'd0, 32'd0, 16'sh0100, 16'sd0, 16'd9999, 1'b0, 16'sd0, CS_WITHIN},
        '{ROW_ITEM, 3'd0, 32'd0, 16'sh0100, 16'sd0, 16'd10000, 1'b0, 16'sd0, CS_WITHIN},
        '{ROW_ITEM, 3'd0, 32'd0, 16'sh0100, 16'sd0, 16'd1, 1'b0, 16'sd0, CS_WITHIN},
        '{ROW_ITEM, 3'd0, 32'd0, 16'sh8000, 16'sh8000, 16'd9999, 1'b0, 16'sd0, CS_WITHIN},
        // PI: rate ignored
        '{ROW_CFG, REG_MODE, 32'(MODE_PI), 16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0, CS_WITHIN},
        '{ROW_ITEM, 3'd0, 32'd0, 16'sh0100, 16'sh7FFF, 16'd500, 1'b0, 16'sd0, CS_WITHIN},
        // PD: integral frozen
        '{ROW_CFG, REG_MODE, 32'(MODE_PD), 16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0, CS_WITHIN},
        '{ROW_ITEM, 3'd0, 32'd0, 16'sh7FFF, 16'sh8000, 16'd500, 1'b0, 16'sd0, CS_WITHIN},
        // spare mode code runs as PID
        '{ROW_CFG, REG_MODE, 32'(MODE_SPARE), 16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0, CS_WITHIN},
        '{ROW_ITEM, 3'd0, 32'd0, 16'shFF00, 16'sh0100, 16'd500, 1'b0, 16'sd0, CS_WITHIN},
        // inverted limits: max test wins
        '{ROW_CFG, REG_MIN, 32'd50, 16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0, CS_WITHIN},
        '{ROW_CFG, REG_MAX, 32'hFFFF_FFCE, 16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0, CS_WITHIN},
        '{ROW_ITEM, 3'd0, 32'd0, 16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0, CS_WITHIN},
        '{ROW_ITEM, 3'd0, 32'd0, 16'sh7FFF, 16'sh7FFF, 16'd9999, 1'b0, 16'sd0, CS_WITHIN},
        // write to an unmapped index must change nothing
        '{ROW_CFG, REG_UNUSED, 32'hFFFF_FFFF, 16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0, CS_WITHIN},
        '{ROW_ITEM, 3'd0, 32'd0, 16'sh0100, 16'sd0, 16'd100, 1'b0, 16'sd0, CS_WITHIN},
        // most negative integral gain, full-range limits
        '{ROW_CFG, REG_KI, 32'h8000_0000, 16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0, CS_WITHIN},
        '{ROW_CFG, REG_MIN, 32'hFFFF_8000, 16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0, CS_WITHIN},
        '{ROW_CFG, REG_MAX, 32'h0000_7FFF, 16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0, CS_WITHIN},
        '{ROW_ITEM, 3'd0, 32'd0, 16'sh7FFF, 16'sd0, 16'd9999, 1'b0, 16'sd0, CS_WITHIN},
        '{ROW_ITEM, 3'd0, 32'd0, 16'sh8000, 16'sd0, 16'd9999, 1'b0, 16'sd0, CS_WITHIN}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pidci_in_if  in_if ();
    pidci_out_if out_if ();

    pid_with_conditional_integration dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the block's registers and integral
    t_s16               kp_r, kd_r, min_r, max_r;
    logic signed [31:0] ki_r;
    logic [1:0]         mode_r;
    logic signed [47:0] integ_r;

    t_drive expected_drive_q [$];
    t_drive exp_res;

    int idle_pct = 12;
    int hold_req = 0;
    int hold_done = 0;
    int fail_count = 0;
    int results_checked = 0;
    int items_sent = 0;
    int reg_writes = 0;

    // Clock
    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // Integral term in Q.16: floor(ki * integral / 2^28)
    function automatic logic signed [63:0] integ_term();
        logic signed [79:0] prod;
        prod = ki_r * integ_r;
        return 64'(prod >>> 28);
    endfunction

    // One controller update: conditional integration, then clamp
    function automatic t_drive predict_drive(input t_s16 err, input t_s16 rate,
                                             input logic [15:0] step);
        logic signed [63:0] prop, rate_term, hi_lim, lo_lim, raw, sum;
        logic               frozen;
        t_drive             res;
        frozen    = (mode_r == MODE_PD);
        prop      = kp_r * err;
        rate_term = (mode_r == MODE_PI) ? 64'sd0 : kd_r * rate;
        hi_lim    = max_r * 64'sd65536;
        lo_lim    = min_r * 64'sd65536;
        raw       = prop - rate_term + (frozen ? 64'sd0 : integ_term());
        if (!frozen && ki_r != 0 && step != 0 && step < DT_LIMIT_US) begin
            if ((raw > hi_lim && err < 0) || (raw < lo_lim && err > 0) ||
                (raw >= lo_lim && raw < hi_lim)) begin
                sum = integ_r + err * $signed({1'b0, step});
                if (sum > INTEG_MAX) sum = INTEG_MAX;
                if (sum < INTEG_MIN) sum = INTEG_MIN;
                integ_r = sum[47:0];
            end
        end
        raw = prop - rate_term + (frozen ? 64'sd0 : integ_term());
        if (raw >= hi_lim) begin
            res.drive = max_r;
            res.cs    = CS_MAX;
        end else if (raw <= lo_lim) begin
            res.drive = min_r;
            res.cs    = CS_MIN;
        end else begin
            res.drive = raw[31:16];
            res.cs    = CS_WITHIN;
        end
        return res;
    endfunction

    // Random signed Q0.16 gain, weighted toward extremes and small values
    function automatic t_s16 rand_gain16();
        t_s16 g;
        case ($urandom_range(3))
            0: g = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            1: g = 16'($urandom);
            default: begin
                g = 16'($urandom_range(0, 1024));
                if ($urandom_range(1)) g = -g;
            end
        endcase
        return g;
    endfunction

    // APB register write; the shadow is updated once the access ends
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_KP:   kp_r   = val[15:0];
            REG_KI:   ki_r   = val;
            REG_KD:   kd_r   = val[15:0];
            REG_MIN:  min_r  = val[15:0];
            REG_MAX:  max_r  = val[15:0];
            REG_MODE: mode_r = val[1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // Offer one update, with random idle cycles ahead of it
    task automatic send_item(input t_s16 err, input t_s16 rate, input logic [15:0] step,
                             input logic use_typed, input t_drive typed_res);
        t_drive pred;
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.error_in <= err;
        in_if.rate_in  <= rate;
        in_if.step_us  <= step;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        pred = predict_drive(err, rate, step);
        expected_drive_q.push_back(use_typed ? typed_res : pred);
        items_sent++;
    endtask

    // Drop valid and wait until every expected result is back
    task automatic settle_input();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_drive_q.size() != 0) @(posedge i_clk);
    endtask

    // Output side: random ready, plus one long hold on request
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_done) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done++;
            end
            out_if.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Score each result transfer against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_drive_q.size() == 0) begin
                $display("%0t: unexpected result drive %0d state %0d", $time,
                         out_if.drive_out, out_if.clamp_state);
                fail_count++;
            end else begin
                exp_res = expected_drive_q.pop_front();
                if (out_if.drive_out !== exp_res.drive) begin
                    $display("%0t: drive_out expected %0d actual %0d", $time,
                             exp_res.drive, out_if.drive_out);
                    fail_count++;
                end
                if (out_if.clamp_state !== exp_res.cs) begin
                    $display("%0t: clamp_state expected %0d actual %0d", $time,
                             exp_res.cs, out_if.clamp_state);
                    fail_count++;
                end
                results_checked++;
            end
        end
    end

    // Watchdog
    initial begin
        #(RUN_LIMIT_NS);
        $display("%0t: timeout, %0d results still expected", $time, expected_drive_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Main sequence
    initial begin
        t_s16               e, r, lo_v, hi_v, a, b;
        logic [15:0]        st;
        logic signed [31:0] ki_v;
        logic               drift_neg;
        int                 wait_cycles;

        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_if.valid    = 1'b0;
        in_if.error_in = '0;
        in_if.rate_in  = '0;
        in_if.step_us  = '0;
        drift_neg      = 1'b0;

        // shadow reset state
        kp_r    = '0;
        ki_r    = '0;
        kd_r    = '0;
        min_r   = 16'sh8000;
        max_r   = 16'sh7FFF;
        mode_r  = MODE_PID;
        integ_r = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == ROW_CFG) begin
                settle_input();
                write_reg(DIRECTED[i].reg_idx, DIRECTED[i].reg_val);
            end else begin
                send_item(DIRECTED[i].err, DIRECTED[i].rate, DIRECTED[i].step,
                          DIRECTED[i].typed, {DIRECTED[i].exp_drive, DIRECTED[i].exp_cs});
            end
        end

        // Random phases, each with its own register setting
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle_input();
            if (ph == 0) begin
                write_reg(REG_KP, 32'h0000_7FFF);
                write_reg(REG_KI, 32'h7FFF_FFFF);
                write_reg(REG_KD, 32'h0000_8000);
                write_reg(REG_MIN, 32'hFFFF_8000);
                write_reg(REG_MAX, 32'h0000_7FFF);
                write_reg(REG_MODE, 32'(MODE_PID));
            end else if (ph == 1) begin
                write_reg(REG_KP, 32'h0000_8000);
                write_reg(REG_KI, 32'h8000_0000);
                write_reg(REG_KD, 32'h0000_7FFF);
                write_reg(REG_MIN, 32'hFFFF_FC18);
                write_reg(REG_MAX, 32'h0000_03E8);
                write_reg(REG_MODE, 32'(MODE_PI));
            end else begin
                case ($urandom_range(3))
                    0: ki_v = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                    default: begin
                        ki_v = $urandom >> $urandom_range(4, 31);
                        if ($urandom_range(1)) ki_v = -ki_v;
                    end
                endcase
                a = 16'($urandom);
                b = 16'($urandom);
                case ($urandom_range(9))
                    0: begin
                        lo_v = 16'sh8000;
                        hi_v = 16'sh7FFF;
                    end
                    1: begin
                        lo_v = (a > b) ? a : b;
                        hi_v = (a > b) ? b : a;
                    end
                    2: begin
                        lo_v = (a > b) ? b : a;
                        hi_v = (a > b) ? a : b;
                    end
                    default: begin
                        lo_v = -$signed(16'($urandom_range(0, 4000)));
                        hi_v = 16'($urandom_range(0, 4000));
                    end
                endcase
                write_reg(REG_KP, 32'(rand_gain16()));
                write_reg(REG_KI, ki_v);
                write_reg(REG_KD, 32'(rand_gain16()));
                write_reg(REG_MIN, 32'(lo_v));
                write_reg(REG_MAX, 32'(hi_v));
                write_reg(REG_MODE, 32'($urandom_range(3)));
            end

            // one phase with no idling at all, one with a long output hold
            idle_pct = (ph == 2) ? 0 : 12;
            if (ph == 4) hold_req++;

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // error drifts one way for a while so the output winds into a limit
                if (n % 24 == 0) drift_neg = 1'($urandom_range(1));
                case ($urandom_range(9))
                    0: begin
                        case ($urandom_range(3))
                            0: e = 16'sh7FFF;
                            1: e = 16'sh8000;
                            2: e = 16'sd0;
                            default: e = -16'sd1;
                        endcase
                    end
                    1, 2: e = 16'($urandom);
                    default: begin
                        e = 16'($urandom_range(0, 4095));
                        if (drift_neg) e = -e;
                    end
                endcase
                case ($urandom_range(4))
                    0: r = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                    default: r = 16'($urandom);
                endcase
                case ($urandom_range(9))
                    0: begin
                        case ($urandom_range(3))
                            0: st = 16'd0;
                            1: st = DT_LIMIT_US - 16'd1;
                            2: st = DT_LIMIT_US;
                            default: st = 16'hFFFF;
                        endcase
                    end
                    1: st = 16'($urandom);
                    default: st = 16'($urandom_range(1, 9999));
                endcase
                send_item(e, r, st, 1'b0, '0);
            end
        end

        // Drain, then watch for stray results
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        wait_cycles = 0;
        while (expected_drive_q.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        if (expected_drive_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     expected_drive_q.size());
            fail_count++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Ran %0d updates (%0d directed rows), scored %0d results, %0d register writes",
                 items_sent, NUM_DIR, results_checked, reg_writes);
        $display("Covered all loop modes, inverted limits, step bounds and a long output hold");
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
